// File: hw/rtl/blr_pkg.sv
// Shared types and constants for the block linear ramp generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package blr_pkg;

   localparam int VAL_W    = 32;   // Q16.16 sample, target and time width
   localparam int FUNC_W   = 2;
   localparam int TICKS_W  = 24;   // blocks per millisecond, Q8.16
   localparam int TIME_W   = 31;   // ramp time, never negative
   localparam int PROD_W   = TIME_W + TICKS_W;
   localparam int BLOCKS_W = PROD_W - 32;  // integer part of time times rate
   localparam int DIVQ_W   = VAL_W + 1;    // magnitude of target minus current

   localparam logic [FUNC_W-1:0] FUNC_SET_TIME   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_TARGET = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd3;

   // Request to the shared divider.
   typedef struct packed {
      logic                start;
      logic                neg;
      logic [DIVQ_W-1:0]   dividend;
      logic [BLOCKS_W-1:0] divisor;
   } div_req_type;

   // Answer from the shared divider: quotient with sign, saturated to 32 bits.
   typedef struct packed {
      logic                    done;
      logic signed [VAL_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hw/rtl/blr_if.sv
// Valid/ready channel interfaces for the ramp generator requests and samples.
// Depends on blr_pkg for the field widths.
`timescale 1ns / 1ps

interface blr_req_if;
   import blr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface blr_rsp_if;
   import blr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] sample;
   logic                    last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: hw/rtl/block_linear_ramp_generator_core.sv
// Block linear ramp generator: set_time, set_target and stop requests are handled while idle.
// A block tick goes straight to its samples when no new target or stop is pending; when it
// first turns a new target into a slope it runs one multiply, then the shared divider unless
// the ramp has no blocks; a stop skips both. Samples then leave one per cycle while rsp is ready.
// Reset is synchronous and active high; it clears all ramp state and loads the rate
// register with 45158.
`timescale 1ns / 1ps

module block_linear_ramp_generator_core #(
   parameter int VECTOR = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   blr_req_if.sink                      req_ch,
   blr_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [blr_pkg::TICKS_W-1:0]  csr_wr_data
);
   import blr_pkg::*;

   // The per-sample step is the block slope shifted by floor(log2(VECTOR)).
   localparam int SHIFT = $clog2(VECTOR + 1) - 1;
   localparam int CNT_W = (VECTOR > 1) ? $clog2(VECTOR) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VECTOR - 1);

   // The sequencer walks a tick through multiply, divide, block setup and emission.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_START,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Architectural ramp state.
   logic [TIME_W-1:0]       pending_ff, pending_in;
   logic [TIME_W-1:0]       ramp_ff, ramp_in;
   logic signed [VAL_W-1:0] target_ff, target_in;
   logic signed [VAL_W-1:0] base_ff, base_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic [BLOCKS_W-1:0]     blocks_ff, blocks_in;
   logic signed [VAL_W-1:0] btarget_ff, btarget_in;
   logic signed [VAL_W-1:0] slope_ff, slope_in;
   logic                    stop_ff, stop_in;
   logic                    rebase_ff, rebase_in;
   logic                    retarget_ff, retarget_in;
   logic [TICKS_W-1:0]      ticks_ff, ticks_in;

   // Working registers for one block.
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [VAL_W-1:0] acc_ff, acc_in;
   logic signed [VAL_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    last_ff, last_in;

   // Shared saturating adder, used for the block update and for each sample.
   logic signed [VAL_W-1:0] add_a, add_b, add_sat;
   logic signed [VAL_W:0]   add_sum;

   // Divider hookup.
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic signed [VAL_W:0]   diff;
   logic [BLOCKS_W-1:0]     blocks_new;

   logic req_fire;
   logic rsp_fire;

   blr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = acc_ff;
   assign rsp_ch.last   = last_ff;
   assign rsp_fire      = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      if (state_ff == ST_START) begin
         add_a = cur_ff;
         add_b = slope_ff;
      end else begin
         add_a = acc_ff;
         add_b = step_ff;
      end
      add_sum = {add_a[VAL_W-1], add_a} + {add_b[VAL_W-1], add_b};
      if (add_sum[VAL_W] != add_sum[VAL_W-1])
         add_sat = add_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      else
         add_sat = add_sum[VAL_W-1:0];
   end

   // The integer part of ramp time times blocks per millisecond is the block count.
   // The slope divides target minus current, taken as sign and magnitude.
   always_comb begin
      blocks_new       = prod_ff[PROD_W-1:32];
      diff             = {target_ff[VAL_W-1], target_ff} - {cur_ff[VAL_W-1], cur_ff};
      div_req.start    = (state_ff == ST_LOAD) && (blocks_new != '0);
      div_req.neg      = diff[VAL_W];
      div_req.dividend = diff[VAL_W] ? DIVQ_W'(-diff) : DIVQ_W'(diff);
      div_req.divisor  = blocks_new;
   end

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      ramp_in      = ramp_ff;
      target_in    = target_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      blocks_in    = blocks_ff;
      btarget_in   = btarget_ff;
      slope_in     = slope_ff;
      stop_in      = stop_ff;
      rebase_in    = rebase_ff;
      retarget_in  = retarget_ff;
      ticks_in     = csr_wr_en ? csr_wr_data : ticks_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.func)
                  FUNC_SET_TIME: begin
                     // Negative times clamp to zero.
                     pending_in = req_ch.value[VAL_W-1] ? '0 : req_ch.value[TIME_W-1:0];
                  end
                  FUNC_SET_TARGET: begin
                     target_in   = req_ch.value;
                     ramp_in     = pending_ff;
                     pending_in  = '0;
                     stop_in     = 1'b0;
                     retarget_in = 1'b1;
                     // A zero ramp time jumps straight to the target at the next tick.
                     if (pending_ff == '0) begin
                        base_in   = req_ch.value;
                        rebase_in = 1'b1;
                     end
                  end
                  FUNC_STOP: begin
                     stop_in     = 1'b1;
                     retarget_in = 1'b1;
                  end
                  default: begin
                     // Block tick: a latched command is folded in before the samples.
                     if (retarget_ff) begin
                        if (rebase_ff)
                           cur_in = base_ff;
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_START;
                     end
                  end
               endcase
            end
         end

         ST_MUL: begin
            stop_in     = 1'b0;
            rebase_in   = 1'b0;
            retarget_in = 1'b0;
            if (stop_ff) begin
               // Freeze at the current value.
               target_in  = cur_ff;
               btarget_in = cur_ff;
               blocks_in  = '0;
               slope_in   = '0;
               state_in   = ST_START;
            end else begin
               prod_in  = ramp_ff * ticks_ff;
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            blocks_in  = blocks_new;
            btarget_in = target_ff;
            if (blocks_new != '0) begin
               state_in = ST_DIV;
            end else begin
               slope_in = '0;
               state_in = ST_START;
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               slope_in = div_rsp.quotient;
               state_in = ST_START;
            end
         end

         ST_START: begin
            // A running ramp advances the block by its slope; a finished one
            // holds the target, which an all-zero step reproduces.
            if (blocks_ff != '0) begin
               acc_in    = cur_ff;
               step_in   = slope_ff >>> SHIFT;
               cur_in    = add_sat;
               blocks_in = blocks_ff - 1'b1;
            end else begin
               acc_in  = btarget_ff;
               step_in = '0;
               cur_in  = btarget_ff;
            end
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
            last_in      = (CNT_LAST == '0);
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_fire) begin
               if (cnt_ff == CNT_LAST) begin
                  rsp_valid_in = 1'b0;
                  last_in      = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  acc_in  = add_sat;
                  cnt_in  = cnt_ff + 1'b1;
                  last_in = ((cnt_ff + 1'b1) == CNT_LAST);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         ramp_ff      <= '0;
         target_ff    <= '0;
         base_ff      <= '0;
         cur_ff       <= '0;
         blocks_ff    <= '0;
         btarget_ff   <= '0;
         slope_ff     <= '0;
         stop_ff      <= 1'b0;
         rebase_ff    <= 1'b0;
         retarget_ff  <= 1'b0;
         ticks_ff     <= TICKS_W'(45158);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         ramp_ff      <= ramp_in;
         target_ff    <= target_in;
         base_ff      <= base_in;
         cur_ff       <= cur_in;
         blocks_ff    <= blocks_in;
         btarget_ff   <= btarget_in;
         slope_ff     <= slope_in;
         stop_ff      <= stop_in;
         rebase_ff    <= rebase_in;
         retarget_ff  <= retarget_in;
         ticks_ff     <= ticks_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

endmodule

// File: hw/rtl/blr_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturation.
// Depends on blr_pkg for the request and answer structs.
`timescale 1ns / 1ps

module blr_div (
   input  logic                clock,
   input  logic                reset,
   input  blr_pkg::div_req_type req,
   output blr_pkg::div_rsp_type rsp
);
   import blr_pkg::*;

   localparam int CNT_W = $clog2(DIVQ_W);

   logic [DIVQ_W-1:0]   dvd_ff, dvd_in;
   logic [BLOCKS_W-1:0] dsr_ff, dsr_in;
   logic [BLOCKS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;

   logic [BLOCKS_W:0]   trial;
   logic [BLOCKS_W:0]   trial_sub;
   logic                fits;

   always_comb begin
      trial     = {rem_ff, dvd_ff[DIVQ_W-1]};
      fits      = (trial >= {1'b0, dsr_ff});
      trial_sub = trial - {1'b0, dsr_ff};

      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;

      if (req.start) begin
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[BLOCKS_W-1:0] : trial[BLOCKS_W-1:0];
         dvd_in = {dvd_ff[DIVQ_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // The quotient magnitude has 33 bits; fold it back into the signed range.
   always_comb begin
      rsp.done = done_ff;
      if (neg_ff) begin
         if (dvd_ff > {2'b01, {(DIVQ_W-2){1'b0}}})
            rsp.quotient = {1'b1, {(VAL_W-1){1'b0}}};
         else
            rsp.quotient = $signed(-dvd_ff[VAL_W-1:0]);
      end else begin
         if (dvd_ff[DIVQ_W-1] || dvd_ff[VAL_W-1])
            rsp.quotient = {1'b0, {(VAL_W-1){1'b1}}};
         else
            rsp.quotient = $signed(dvd_ff[VAL_W-1:0]);
      end
   end

endmodule

// File: tb/sv/tb_block_linear_ramp_generator_core.sv
// Self-checking testbench for block_linear_ramp_generator_core: directed and random
// requests, an in-bench ramp predictor, and a sample-by-sample scoreboard.
// Depends on blr_pkg and the blr_req_if / blr_rsp_if interfaces of the RTL.
`timescale 1ns / 1ps

module tb_block_linear_ramp_generator_core;
   import blr_pkg::*;

   localparam int VECTOR       = 64;
   // Floor of log2(VECTOR): the per-sample stride is the block slope shifted by this.
   localparam int VEC_SHIFT    = $clog2(VECTOR + 1) - 1;
   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_OFF     = 800;

   // One expected sample as it leaves the result channel.
   typedef struct packed {
      logic signed [VAL_W-1:0] sample;
      logic                    last;
   } ramp_sample_type;

   // One row of the directed table.  Where fixed is set, a block tick must give
   // VECTOR copies of the typed sample; otherwise the predictor decides.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VAL_W-1:0]  value;
      logic              fixed;
      logic [VAL_W-1:0]  sample;
   } stim_row_type;

   localparam stim_row_type PRESET_ROWS [25] = '{
      // Straight after reset the output sits at zero.
      '{FUNC_TICK,       32'h0000_0000, 1'b1, 32'h0000_0000},
      // A target with no ramp time jumps there at once: full-scale positive.
      '{FUNC_SET_TARGET, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
      // A negative ramp time clamps to zero, so the next target jumps too.
      '{FUNC_SET_TIME,   32'h8000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_SET_TARGET, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b1, 32'h8000_0000},
      // Two milliseconds is a single block at the reset rate: the slope from the
      // negative extreme to the positive one saturates.
      '{FUNC_SET_TIME,   32'h0002_0000, 1'b0, 32'h0000_0000},
      '{FUNC_SET_TARGET, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
      // Longest ramp time, then a stop with junk in the value field freezes it.
      '{FUNC_SET_TIME,   32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{FUNC_SET_TARGET, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_STOP,       32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      // A stop that a later target overrides: the ramp runs again.
      '{FUNC_SET_TIME,   32'h000A_8000, 1'b0, 32'h0000_0000},
      '{FUNC_STOP,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_SET_TARGET, 32'hFFFF_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b0, 32'h0000_0000},
      // The pending time was used up, so this target jumps; a tick ignores its value.
      '{FUNC_SET_TARGET, 32'h0005_0000, 1'b0, 32'h0000_0000},
      '{FUNC_TICK,       32'h0000_0000, 1'b1, 32'h0005_0000},
      '{FUNC_TICK,       32'hFFFF_FFFF, 1'b1, 32'h0005_0000}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [TICKS_W-1:0] csr_wr_data = '0;

   blr_req_if req_if ();
   blr_rsp_if rsp_if ();

   block_linear_ramp_generator_core #(
      .VECTOR (VECTOR)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Ramp predictor.  It mirrors the block's state and is stepped once per
   // accepted request, in acceptance order.
   // ------------------------------------------------------------------------
   logic [TICKS_W-1:0]      rate_q16     = 24'd45158;
   logic signed [VAL_W-1:0] pending_ms   = '0;
   logic signed [VAL_W-1:0] ramp_ms      = '0;
   logic signed [VAL_W-1:0] goal_level   = '0;
   logic signed [VAL_W-1:0] jump_level   = '0;
   logic signed [VAL_W-1:0] level        = '0;
   logic [31:0]             blocks_to_go = '0;
   logic signed [VAL_W-1:0] block_goal   = '0;
   logic signed [VAL_W-1:0] block_slope  = '0;
   logic                    freeze_req   = 1'b0;
   logic                    jump_req     = 1'b0;
   logic                    new_goal     = 1'b0;

   ramp_sample_type expected_samples [$];

   int          requests_sent   = 0;
   int          samples_checked = 0;
   int          mismatch_count  = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_off_left   = 0;
   int unsigned cycle_count     = 0;

   function automatic logic signed [VAL_W-1:0] clamp_q16(input longint v);
      if (v > longint'(32'sh7FFF_FFFF))
         return 32'sh7FFF_FFFF;
      if (v < -longint'(64'sh8000_0000))
         return 32'sh8000_0000;
      return v[VAL_W-1:0];
   endfunction

   // Advances the predictor by one request.  Block ticks push VECTOR samples
   // unless keep is clear, in which case the caller supplies the expectation.
   task automatic predict_request(input logic [FUNC_W-1:0] f,
                                  input logic signed [VAL_W-1:0] v, input bit keep);
      longint                  prod;
      longint                  diff;
      logic signed [VAL_W-1:0] acc;
      logic signed [VAL_W-1:0] stride;
      int                      k;
      case (f)
         FUNC_SET_TIME: begin
            pending_ms = (v < 0) ? '0 : v;
         end
         FUNC_SET_TARGET: begin
            goal_level = v;
            ramp_ms    = pending_ms;
            pending_ms = '0;
            freeze_req = 1'b0;
            new_goal   = 1'b1;
            if (ramp_ms == 0) begin
               jump_level = v;
               jump_req   = 1'b1;
            end
         end
         FUNC_STOP: begin
            freeze_req = 1'b1;
            new_goal   = 1'b1;
         end
         default: begin
            // A latched command is applied first: turn time into blocks and
            // work out the per-block slope.
            if (new_goal) begin
               if (jump_req)
                  level = jump_level;
               if (freeze_req) begin
                  goal_level   = level;
                  blocks_to_go = '0;
               end else begin
                  prod = longint'(ramp_ms) * longint'({8'd0, rate_q16});
                  blocks_to_go = prod[63:32];
               end
               block_goal = goal_level;
               if (blocks_to_go != 0) begin
                  diff = longint'(goal_level) - longint'(level);
                  block_slope = clamp_q16(diff / longint'({32'd0, blocks_to_go}));
               end else begin
                  block_slope = '0;
               end
               freeze_req = 1'b0;
               jump_req   = 1'b0;
               new_goal   = 1'b0;
            end
            if (blocks_to_go != 0) begin
               acc    = level;
               stride = block_slope >>> VEC_SHIFT;
               level  = clamp_q16(longint'(level) + longint'(block_slope));
               for (k = 0; k < VECTOR; k++) begin
                  if (keep)
                     expected_samples.push_back('{sample: acc, last: (k == VECTOR - 1)});
                  acc = clamp_q16(longint'(acc) + longint'(stride));
               end
               blocks_to_go = blocks_to_go - 1;
            end else begin
               level = block_goal;
               for (k = 0; k < VECTOR; k++)
                  if (keep)
                     expected_samples.push_back('{sample: block_goal,
                                                  last: (k == VECTOR - 1)});
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      mismatch_count++;
      $display("tb: mismatch in %s at sample %0d: got %h, want %h",
               what, samples_checked, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Request driver.  Valid stays high from one accepted request into the
   // next unless an idle gap is rolled, so valid is never dropped and raised
   // in the same step.  Idle cycles carry junk on the payload.
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v,
                               input bit fixed, input logic [VAL_W-1:0] fixed_sample);
      int k;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.func  <= FUNC_W'($urandom);
         req_if.value <= $urandom;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= f;
      req_if.value <= v;
      do
         @(posedge clock);
      while (!req_if.ready);
      requests_sent++;
      predict_request(f, v, !fixed);
      if (fixed && f == FUNC_TICK)
         for (k = 0; k < VECTOR; k++)
            expected_samples.push_back('{sample: fixed_sample, last: (k == VECTOR - 1)});
   endtask

   // ------------------------------------------------------------------------
   // Sample receiver.  A long hold-off, when armed, takes priority over the
   // random stalls so that the block backs up into its request input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Scoreboard: every sample taken off the result channel is checked against
   // the oldest expectation, field by field.
   always @(posedge clock) begin : check_samples
      ramp_sample_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected sample", rsp_if.sample, '0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_if.sample !== want.sample)
               report_mismatch("sample", rsp_if.sample, want.sample);
            if (rsp_if.last !== want.last)
               report_mismatch("last", {31'd0, rsp_if.last}, {31'd0, want.last});
         end
         samples_checked++;
      end
   end

   // Watchdog: the run must finish well inside this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, the directed table at the reset rate, then four
   // random phases, each with its own rate setting and idling pattern.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int                p;
      int                i;
      int                ticks;
      int                stop_at;
      int                mid_rate;
      logic [TICKS_W-1:0] new_rate;
      logic [VAL_W-1:0]  t;
      logic [VAL_W-1:0]  goal;
      longint unsigned   span;

      req_if.valid  = 1'b0;
      req_if.func   = FUNC_SET_TIME;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      mid_rate      = $urandom_range(1000, 400000);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++)
         send_request(PRESET_ROWS[i].func, PRESET_ROWS[i].value,
                      PRESET_ROWS[i].fixed, PRESET_ROWS[i].sample);

      for (p = 0; p < 4; p++) begin
         // The rate register is only written with the block idle: drain all
         // samples, then allow for a tick that may still be computing a slope.
         req_if.valid <= 1'b0;
         while (expected_samples.size() != 0)
            @(posedge clock);
         repeat (VECTOR + 48) @(posedge clock);

         case (p)
            0:       new_rate = {TICKS_W{1'b1}};
            1:       new_rate = '0;
            2:       new_rate = TICKS_W'(mid_rate);
            default: new_rate = 24'd45158;
         endcase
         csr_wr_en   <= 1'b1;
         csr_wr_data <= new_rate;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         rate_q16   = new_rate;

         // Idling patterns: none, sender gaps, receiver stalls, then both lightly.
         case (p)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
            1:       begin sender_idle_pct = 61; receiver_stall_pct <= 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct <= 61; end
            default: begin sender_idle_pct = 12; receiver_stall_pct <= 12; end
         endcase
         // In the first phase the sender never pauses, so a long receiver
         // hold-off fills the block and pushes back on its request input.
         if (p == 0)
            hold_off_left <= HOLD_OFF;

         while (requests_sent < 25 + 72 * (p + 1)) begin
            if ($urandom_range(0, 99) < 80) begin
               // Well-formed ramp: optional time, a target, then a run of ticks
               // with a stop now and then.
               if ($urandom_range(0, 3) != 0) begin
                  case ($urandom_range(0, 9))
                     0: t = $urandom | 32'h8000_0000;
                     1: t = $urandom & 32'h7FFF_FFFF;
                     2: t = '0;
                     default: begin
                        // Keep most ramps within a handful of blocks at this rate.
                        span = (rate_q16 == 0) ? 64'h7FFF_FFFF
                                               : (64'd8 << 32) / rate_q16;
                        if (span > 64'h7FFF_FFFF)
                           span = 64'h7FFF_FFFF;
                        t = $urandom_range(0, 32'(span));
                     end
                  endcase
                  send_request(FUNC_SET_TIME, t, 1'b0, '0);
               end
               case ($urandom_range(0, 7))
                  0:       goal = 32'h7FFF_FFFF;
                  1:       goal = 32'h8000_0000;
                  2:       goal = '0;
                  default: goal = $urandom;
               endcase
               send_request(FUNC_SET_TARGET, goal, 1'b0, '0);
               ticks   = $urandom_range(1, 10);
               stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ticks - 1) : -1;
               for (i = 0; i < ticks; i++) begin
                  if (i == stop_at)
                     send_request(FUNC_STOP, $urandom, 1'b0, '0);
                  send_request(FUNC_TICK, $urandom, 1'b0, '0);
               end
            end else begin
               // Noise: any command with any value.
               send_request(FUNC_W'($urandom), $urandom, 1'b0, '0);
            end
         end
      end

      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      // Anything the block emits beyond the predicted samples shows up here.
      repeat (VECTOR + 64) @(posedge clock);

      $display("tb: %0d requests driven, %0d samples checked, %0d mismatches",
               requests_sent, samples_checked, mismatch_count);
      $display("tb: rates covered zero, full scale, %0d and 45158 under four idle patterns",
               mid_rate);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
